// ===== sv/ptd_pkg.sv =====
// Shared types and constants for the periodic task dispatcher.
package ptd_pkg;

	localparam int TIME_W  = 16;
	localparam int TAG_W   = 8;
	localparam int SLOT_W  = 3;
	localparam int OP_W    = 2;
	localparam int ENTRY_W = 2 * TIME_W + TAG_W;

	localparam logic [OP_W-1:0] OP_INIT     = 2'd0;
	localparam logic [OP_W-1:0] OP_ADD      = 2'd1;
	localparam logic [OP_W-1:0] OP_DISPATCH = 2'd2;

	localparam logic [TIME_W-1:0] IDLE_NONE = 16'hFFFF;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_EMIT
	} ptd_state_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic emit;
	} ptd_cmd_t;

	typedef struct packed {
		logic used_zero;
		logic last_slot;
	} ptd_sts_t;

endpackage

// ===== sv/ptd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ptd_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 8
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== sv/ptd_ctrl.sv =====
// Controller state machine that sequences operations and the table scan.
module ptd_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [ptd_pkg::OP_W-1:0] operation,
	output logic                   out_valid,
	input  logic                   out_stall,
	output ptd_pkg::ptd_cmd_t      cmd,
	input  ptd_pkg::ptd_sts_t      sts
);
	import ptd_pkg::*;

	ptd_state_t state_q, state_d;
	logic       out_valid_q, out_valid_d;
	logic       out_free;
	logic       is_dispatch;

	assign out_free    = !out_valid_q || !out_stall;
	assign is_dispatch = (operation == OP_DISPATCH);
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall   = !out_free;
				cmd.accept = in_valid && out_free;
				if (cmd.accept && is_dispatch) begin
					state_d = sts.used_zero ? S_EMIT : S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.step = 1'b1;
				if (sts.last_slot) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if ((cmd.accept && !is_dispatch) || cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

endmodule

// ===== sv/ptd_datapath.sv =====
// Datapath holding the task table, the time base, the scan accumulators and result registers.
module ptd_datapath #(
	parameter int MAX_TASKS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ptd_pkg::ptd_cmd_t          cmd,
	output ptd_pkg::ptd_sts_t          sts,
	input  logic [ptd_pkg::OP_W-1:0]   operation,
	input  logic [ptd_pkg::TIME_W-1:0] current_time,
	input  logic [ptd_pkg::TIME_W-1:0] start_delay,
	input  logic [ptd_pkg::TIME_W-1:0] task_period,
	input  logic [ptd_pkg::TAG_W-1:0]  task_tag,
	output logic                       ready_res,
	output logic [ptd_pkg::SLOT_W-1:0] ready_slot,
	output logic [ptd_pkg::TAG_W-1:0]  ready_tag,
	output logic [ptd_pkg::TIME_W-1:0] idle_ticks,
	output logic                       conflict,
	output logic                       table_full
);
	import ptd_pkg::*;

	localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CW = $clog2(MAX_TASKS + 1);

	logic [CW-1:0]      used_q;
	logic [TIME_W-1:0]  last_time_q;
	logic [TIME_W-1:0]  elapsed_q;
	logic [IW-1:0]      idx_q;
	logic               picked_q;
	logic               conf_q;
	logic [IW-1:0]      slot_q;
	logic [TAG_W-1:0]   tag_q;
	logic [TIME_W-1:0]  least_q;

	logic               full;
	logic               we;
	logic [IW-1:0]      waddr;
	logic [ENTRY_W-1:0] wdata;
	logic [IW-1:0]      raddr;
	logic [ENTRY_W-1:0] rdata;

	logic [TIME_W-1:0]  cd_rd;
	logic [TIME_W-1:0]  per_rd;
	logic [TAG_W-1:0]   tag_rd;
	logic [TIME_W-1:0]  cd_dec;
	logic [TIME_W-1:0]  cd_wr;
	logic               due;
	logic               take;
	logic [IW+SLOT_W-1:0] slot_ext;

	assign full   = (used_q == CW'(MAX_TASKS));
	assign cd_rd  = rdata[ENTRY_W-1 -: TIME_W];
	assign per_rd = rdata[TAG_W +: TIME_W];
	assign tag_rd = rdata[TAG_W-1:0];
	assign cd_dec = cd_rd - elapsed_q;
	assign due    = (cd_dec == '0) || cd_dec[TIME_W-1];
	assign take   = due && !picked_q;
	assign cd_wr  = take ? (cd_dec + per_rd) : cd_dec;

	assign sts.used_zero = (used_q == '0);
	assign sts.last_slot = (CW'(idx_q) == (used_q - CW'(1)));

	always_comb begin
		we    = 1'b0;
		waddr = idx_q;
		wdata = {cd_wr, per_rd, tag_rd};
		raddr = '0;
		if (cmd.accept && (operation == OP_ADD) && !full) begin
			we    = 1'b1;
			waddr = used_q[IW-1:0];
			wdata = {start_delay, task_period, task_tag};
		end else if (cmd.step) begin
			we    = 1'b1;
			raddr = (idx_q == IW'(MAX_TASKS - 1)) ? '0 : idx_q + IW'(1);
		end
	end

	ptd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(MAX_TASKS)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			last_time_q <= '0;
		end else if (cmd.accept) begin
			if (operation == OP_INIT || operation == OP_DISPATCH) begin
				last_time_q <= current_time;
			end
			if (operation == OP_ADD && !full) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	assign slot_ext = (IW + SLOT_W)'(slot_q);

	always_ff @(posedge clk) begin
		if (cmd.accept && operation == OP_DISPATCH) begin
			elapsed_q <= current_time - last_time_q;
			idx_q     <= '0;
			picked_q  <= 1'b0;
			conf_q    <= 1'b0;
			slot_q    <= '0;
			tag_q     <= '0;
			least_q   <= IDLE_NONE;
		end else if (cmd.step) begin
			idx_q <= idx_q + IW'(1);
			if (take) begin
				picked_q <= 1'b1;
				slot_q   <= idx_q;
				tag_q    <= tag_rd;
			end
			if (due && picked_q) begin
				conf_q <= 1'b1;
			end
			if (due) begin
				least_q <= '0;
			end else if (cd_dec < least_q) begin
				least_q <= cd_dec;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && operation != OP_DISPATCH) begin
			ready_res  <= 1'b0;
			ready_slot <= '0;
			ready_tag  <= '0;
			idle_ticks <= '0;
			conflict   <= 1'b0;
			table_full <= (operation == OP_ADD) && full;
		end else if (cmd.emit) begin
			ready_res  <= picked_q;
			ready_slot <= slot_ext[SLOT_W-1:0];
			ready_tag  <= tag_q;
			idle_ticks <= least_q;
			conflict   <= conf_q;
			table_full <= 1'b0;
		end
	end

endmodule

// ===== sv/periodic_task_dispatcher_unit.sv =====
// Top level of the periodic task dispatcher: controller, datapath and checks.
// Init, add and unused codes give their result beat in the cycle after acceptance, one per
// cycle while the output is not stalled. Dispatch steps through every used table slot in the
// scan state, then emits its result beat once the output is free, accepting nothing until then.
// The scan reads one table slot per cycle through the single table read port.
// Asynchronous reset empties the table, zeroes the time base and drops the result valid.
module periodic_task_dispatcher_unit #(
	parameter int MAX_TASKS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [ptd_pkg::OP_W-1:0]   operation,
	input  logic [ptd_pkg::TIME_W-1:0] current_time,
	input  logic [ptd_pkg::TIME_W-1:0] start_delay,
	input  logic [ptd_pkg::TIME_W-1:0] task_period,
	input  logic [ptd_pkg::TAG_W-1:0]  task_tag,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       ready_res,
	output logic [ptd_pkg::SLOT_W-1:0] ready_slot,
	output logic [ptd_pkg::TAG_W-1:0]  ready_tag,
	output logic [ptd_pkg::TIME_W-1:0] idle_ticks,
	output logic                       conflict,
	output logic                       table_full
);
	import ptd_pkg::*;

	ptd_cmd_t cmd;
	ptd_sts_t sts;

	ptd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.operation(operation),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ptd_datapath #(
		.MAX_TASKS(MAX_TASKS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.operation   (operation),
		.current_time(current_time),
		.start_delay (start_delay),
		.task_period (task_period),
		.task_tag    (task_tag),
		.ready_res   (ready_res),
		.ready_slot  (ready_slot),
		.ready_tag   (ready_tag),
		.idle_ticks  (idle_ticks),
		.conflict    (conflict),
		.table_full  (table_full)
	);

`ifndef SYNTHESIS
	a_no_pick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !ready_res) |-> (ready_slot == '0 && ready_tag == '0))
		else $error("Slot or tag set without a selected task.");

	a_conflict_pick: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && conflict) |-> ready_res)
		else $error("Conflict reported without a selected task.");

	a_pick_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ready_res) |-> (idle_ticks == '0))
		else $error("Selected task with nonzero idle time.");

	a_full_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> (!ready_res && !conflict && idle_ticks == '0))
		else $error("Table full mixed with dispatch results.");
`endif

endmodule
